// ----- hdl/xcmpx_pkg.sv -----
// Shared types and constants for the x86 compare-exchange unit.
package xcmpx_pkg;

  localparam int IN_DATA_W  = 392;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 272;
  localparam int OUT_USER_W = 2;
  localparam int FLAG_W     = 6;

  typedef enum logic [2:0] {
    CMD_BYTE  = 3'd0,
    CMD_WORD  = 3'd1,
    CMD_DWORD = 3'd2,
    CMD_QWORD = 3'd3,
    CMD_8B    = 3'd4,
    CMD_16B   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK = 2'd0,
    STS_GP = 2'd1,
    STS_PF = 2'd2
  } status_t;

  // flag bit positions
  localparam int FLG_CF = 0;
  localparam int FLG_ZF = 1;
  localparam int FLG_PF = 2;
  localparam int FLG_AF = 3;
  localparam int FLG_SF = 4;
  localparam int FLG_OF = 5;

  localparam logic [FLAG_W-1:0] MASK_SIZED = 6'h3F;
  localparam logic [FLAG_W-1:0] MASK_WIDE  = 6'h02;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] memory_low;
    logic [63:0] memory_high;
    logic [63:0] accum_low;
    logic [63:0] accum_high;
    logic [63:0] source_low;
    logic [63:0] source_high;
    logic [3:0]  address_low_bits;
    logic        read_fault;
    logic        write_fault;
  } xcmpx_item_t;

  typedef struct packed {
    status_t           status;
    logic              write_memory;
    logic [63:0]       store_low;
    logic [63:0]       store_high;
    logic              write_accum;
    logic [63:0]       new_accum_low;
    logic [63:0]       new_accum_high;
    logic [FLAG_W-1:0] flag_values;
    logic [FLAG_W-1:0] flag_update_mask;
  } xcmpx_res_t;

endpackage

// ----- hdl/xcmpx_exec.sv -----
// Compare, exchange decision and flag logic for one instruction.
module xcmpx_exec (
  input  xcmpx_pkg::xcmpx_item_t item,
  output xcmpx_pkg::xcmpx_res_t  res
);
  import xcmpx_pkg::*;

  logic [63:0] wmask;
  logic [63:0] a, b, r, ab_x, ar_x;
  logic        sign_r, ovf;
  logic        sized_match;
  logic [63:0] want8;
  logic        match8, match16;
  logic [FLAG_W-1:0] sflags;

  // operand width mask and sign bit for the sized forms
  always_comb begin
    a    = '0;
    b    = '0;
    r    = '0;
    ab_x = '0;
    ar_x = '0;
    unique case (item.command)
      CMD_BYTE:  wmask = 64'h0000_0000_0000_00FF;
      CMD_WORD:  wmask = 64'h0000_0000_0000_FFFF;
      CMD_DWORD: wmask = 64'h0000_0000_FFFF_FFFF;
      default:   wmask = '1;
    endcase
    a    = item.accum_low & wmask;
    b    = item.memory_low & wmask;
    r    = (a - b) & wmask;
    ab_x = a ^ b;
    ar_x = a ^ r;
    unique case (item.command)
      CMD_BYTE: begin
        sign_r = r[7];
        ovf    = ab_x[7] & ar_x[7];
      end
      CMD_WORD: begin
        sign_r = r[15];
        ovf    = ab_x[15] & ar_x[15];
      end
      CMD_DWORD: begin
        sign_r = r[31];
        ovf    = ab_x[31] & ar_x[31];
      end
      default: begin
        sign_r = r[63];
        ovf    = ab_x[63] & ar_x[63];
      end
    endcase
  end

  assign sized_match = (a == b);
  assign want8   = {item.accum_high[31:0], item.accum_low[31:0]};
  assign match8  = (item.memory_low == want8);
  assign match16 = (item.memory_low == item.accum_low) &&
                   (item.memory_high == item.accum_high);

  always_comb begin
    sflags         = '0;
    sflags[FLG_CF] = (a < b);
    sflags[FLG_ZF] = sized_match;
    sflags[FLG_PF] = ~(^r[7:0]);
    sflags[FLG_AF] = ab_x[4] ^ r[4];
    sflags[FLG_SF] = sign_r;
    sflags[FLG_OF] = ovf;
  end

  always_comb begin
    res = '0;
    unique case (item.command) inside
      CMD_BYTE, CMD_WORD, CMD_DWORD, CMD_QWORD: begin
        if (item.read_fault) begin
          res.status = STS_PF;
        end else if (sized_match && item.write_fault) begin
          res.status = STS_PF;
        end else begin
          if (sized_match) begin
            res.write_memory = 1'b1;
            res.store_low    = item.source_low & wmask;
          end else begin
            res.write_accum   = 1'b1;
            res.new_accum_low = b;
          end
          res.flag_values      = sflags;
          res.flag_update_mask = MASK_SIZED;
        end
      end
      CMD_8B: begin
        if (item.address_low_bits[2:0] != 3'd0) begin
          res.status = STS_GP;
        end else if (item.read_fault || (match8 && item.write_fault)) begin
          res.status = STS_PF;
        end else begin
          if (match8) begin
            res.write_memory        = 1'b1;
            res.store_low           = {item.source_high[31:0], item.source_low[31:0]};
            res.flag_values[FLG_ZF] = 1'b1;
          end else begin
            res.write_accum    = 1'b1;
            res.new_accum_low  = {32'd0, item.memory_low[31:0]};
            res.new_accum_high = {32'd0, item.memory_low[63:32]};
          end
          res.flag_update_mask = MASK_WIDE;
        end
      end
      CMD_16B: begin
        if (item.address_low_bits != 4'd0) begin
          res.status = STS_GP;
        end else if (item.read_fault || (match16 && item.write_fault)) begin
          res.status = STS_PF;
        end else begin
          if (match16) begin
            res.write_memory        = 1'b1;
            res.store_low           = item.source_low;
            res.store_high          = item.source_high;
            res.flag_values[FLG_ZF] = 1'b1;
          end else begin
            res.write_accum    = 1'b1;
            res.new_accum_low  = item.memory_low;
            res.new_accum_high = item.memory_high;
          end
          res.flag_update_mask = MASK_WIDE;
        end
      end
      default: res = '0;  // undefined commands do nothing
    endcase
  end

endmodule

// ----- hdl/x86_compare_exchange_unit_top.sv -----
// Top level of the x86 compare-exchange unit: input register, exec logic, result register.
//
//  channel  | direction | data / user contents
//  ---------+-----------+-----------------------------------------------------------
//  in_      | slave     | tuser: command; tdata: memory, accum, source, address, faults
//  out_     | master    | tuser: status; tdata: store, accum update, flags
//
// Two register stages, the input register and the result register; one word is taken every
// cycle while out_tready does not hold the result.
// The input register and the result register each advance when the stage behind them
// is empty or being drained; out_tready low holds the result and backs up to in_tready.
// Reset (rst_n low, synchronous) empties both stages.
module x86_compare_exchange_unit_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [63:0] memory_low, [127:64] memory_high, [191:128] accum_low, [255:192] accum_high,
  // [319:256] source_low, [383:320] source_high, [387:384] address_low_bits,
  // [388] read_fault, [389] write_fault, [391:390] zero
  input  logic [xcmpx_pkg::IN_DATA_W-1:0]     in_tdata,
  // [2:0] command
  input  logic [xcmpx_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] write_memory, [64:1] store_low, [128:65] store_high, [129] write_accum,
  // [193:130] new_accum_low, [257:194] new_accum_high, [263:258] flag_values,
  // [269:264] flag_update_mask, [271:270] zero
  output logic [xcmpx_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [xcmpx_pkg::OUT_USER_W-1:0]    out_tuser
);
  import xcmpx_pkg::*;

  xcmpx_item_t in_item;
  xcmpx_item_t item_r;
  xcmpx_res_t  res;
  xcmpx_res_t  res_r;
  logic        item_vld_r, item_vld_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic        res_adv;
  logic        in_fire;

  always_comb begin
    in_item                  = '0;
    in_item.command          = cmd_t'(in_tuser);
    in_item.memory_low       = in_tdata[63:0];
    in_item.memory_high      = in_tdata[127:64];
    in_item.accum_low        = in_tdata[191:128];
    in_item.accum_high       = in_tdata[255:192];
    in_item.source_low       = in_tdata[319:256];
    in_item.source_high      = in_tdata[383:320];
    in_item.address_low_bits = in_tdata[387:384];
    in_item.read_fault       = in_tdata[388];
    in_item.write_fault      = in_tdata[389];
  end

  xcmpx_exec u_exec (
    .item (item_r),
    .res  (res)
  );

  assign res_adv   = !out_vld_r || out_tready;
  assign in_tready = !item_vld_r || res_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_fire) begin
      item_vld_nxt = 1'b1;
    end else if (res_adv) begin
      item_vld_nxt = 1'b0;
    end
    out_vld_nxt = res_adv ? item_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
    if (res_adv && item_vld_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {2'b00,
                       res_r.flag_update_mask,
                       res_r.flag_values,
                       res_r.new_accum_high,
                       res_r.new_accum_low,
                       res_r.write_accum,
                       res_r.store_high,
                       res_r.store_low,
                       res_r.write_memory};

endmodule

// ----- dv/tb_x86_compare_exchange_unit_top.sv -----
// Testbench for the compare-exchange unit: directed and random words checked against a predictor.
module tb_x86_compare_exchange_unit_top;
  import xcmpx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;
  // commands the unit must treat as no-ops
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] memory_low;
    logic [63:0] memory_high;
    logic [63:0] accum_low;
    logic [63:0] accum_high;
    logic [63:0] source_low;
    logic [63:0] source_high;
    logic [3:0]  address_low_bits;
    logic        read_fault;
    logic        write_fault;
  } cx_op_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  xcmpx_res_t due_results[$];
  int err_count = 0;
  int cycle_count = 0;
  int checked_count = 0;
  int idle_pct_in = 0;
  int stall_pct_out = 0;
  int hold_req = 0;

  x86_compare_exchange_unit_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when a test asks for one
  always @(posedge clk) begin : rx_stall
    int hold_cnt;
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct_out);
    end
  end

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_err($sformatf("word %0d %s: got %h want %h", checked_count, name, got, want));
  endtask

  function automatic logic [63:0] operand_mask(input logic [2:0] cmd);
    case (cmd)
      CMD_BYTE:  return 64'hFF;
      CMD_WORD:  return 64'hFFFF;
      CMD_DWORD: return 64'hFFFF_FFFF;
      default:   return '1;
    endcase
  endfunction

  function automatic xcmpx_res_t predict_cmpxchg(input cx_op_t op);
    xcmpx_res_t  r;
    logic [63:0] m, a, b, d, want;
    int          top;
    logic        hit;
    r = '0;
    case (op.command) inside
      CMD_BYTE, CMD_WORD, CMD_DWORD, CMD_QWORD: begin
        m   = operand_mask(op.command);
        top = (8 << op.command) - 1;
        a   = op.accum_low & m;
        b   = op.memory_low & m;
        hit = (a == b);
        if (op.read_fault || (hit && op.write_fault)) begin
          r.status = STS_PF;
        end else begin
          if (hit) begin
            r.write_memory = 1'b1;
            r.store_low    = op.source_low & m;
          end else begin
            r.write_accum   = 1'b1;
            r.new_accum_low = b;
          end
          d = (a - b) & m;
          r.flag_values[FLG_CF] = (a < b);
          r.flag_values[FLG_ZF] = hit;
          r.flag_values[FLG_PF] = ~^d[7:0];
          r.flag_values[FLG_AF] = a[4] ^ b[4] ^ d[4];
          r.flag_values[FLG_SF] = d[top];
          r.flag_values[FLG_OF] = (a[top] ^ b[top]) & (a[top] ^ d[top]);
          r.flag_update_mask    = MASK_SIZED;
        end
      end
      CMD_8B: begin
        want = {op.accum_high[31:0], op.accum_low[31:0]};
        hit  = (op.memory_low == want);
        // alignment is checked ahead of either fault
        if (op.address_low_bits[2:0] != 3'd0) begin
          r.status = STS_GP;
        end else if (op.read_fault || (hit && op.write_fault)) begin
          r.status = STS_PF;
        end else begin
          if (hit) begin
            r.write_memory          = 1'b1;
            r.store_low             = {op.source_high[31:0], op.source_low[31:0]};
            r.flag_values[FLG_ZF]   = 1'b1;
          end else begin
            r.write_accum    = 1'b1;
            r.new_accum_low  = {32'd0, op.memory_low[31:0]};
            r.new_accum_high = {32'd0, op.memory_low[63:32]};
          end
          r.flag_update_mask = MASK_WIDE;
        end
      end
      CMD_16B: begin
        hit = (op.memory_low == op.accum_low) && (op.memory_high == op.accum_high);
        if (op.address_low_bits != 4'd0) begin
          r.status = STS_GP;
        end else if (op.read_fault || (hit && op.write_fault)) begin
          r.status = STS_PF;
        end else begin
          if (hit) begin
            r.write_memory        = 1'b1;
            r.store_low           = op.source_low;
            r.store_high          = op.source_high;
            r.flag_values[FLG_ZF] = 1'b1;
          end else begin
            r.write_accum    = 1'b1;
            r.new_accum_low  = op.memory_low;
            r.new_accum_high = op.memory_high;
          end
          r.flag_update_mask = MASK_WIDE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // result checker: a word moves at the next edge when both sides are high at negedge
  always @(negedge clk) begin : result_check
    xcmpx_res_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status           = status_t'(out_tuser[1:0]);
      got.write_memory     = out_tdata[0];
      got.store_low        = out_tdata[64:1];
      got.store_high       = out_tdata[128:65];
      got.write_accum      = out_tdata[129];
      got.new_accum_low    = out_tdata[193:130];
      got.new_accum_high   = out_tdata[257:194];
      got.flag_values      = out_tdata[263:258];
      got.flag_update_mask = out_tdata[269:264];
      if (due_results.size() == 0) begin
        report_err("result word with nothing expected");
      end else begin
        want = due_results.pop_front();
        check_field("status", 64'(got.status), 64'(want.status));
        check_field("write_memory", 64'(got.write_memory), 64'(want.write_memory));
        check_field("store_low", got.store_low, want.store_low);
        check_field("store_high", got.store_high, want.store_high);
        check_field("write_accum", 64'(got.write_accum), 64'(want.write_accum));
        check_field("new_accum_low", got.new_accum_low, want.new_accum_low);
        check_field("new_accum_high", got.new_accum_high, want.new_accum_high);
        check_field("flag_values", 64'(got.flag_values), 64'(want.flag_values));
        check_field("flag_update_mask", 64'(got.flag_update_mask),
                    64'(want.flag_update_mask));
      end
      checked_count++;
    end
  end

  task automatic send_op(input cx_op_t op);
    while (idle_pct_in != 0 && $urandom_range(0, 99) < idle_pct_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op.command;
    in_tdata  <= {2'b00, op.write_fault, op.read_fault, op.address_low_bits,
                  op.source_high, op.source_low, op.accum_high, op.accum_low,
                  op.memory_high, op.memory_low};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    due_results.push_back(predict_cmpxchg(op));
  endtask

  // stop sending and let every expected word come back
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic cx_op_t make_op(input logic [2:0] cmd, input logic [63:0] mlo,
                                     input logic [63:0] mhi, input logic [63:0] alo,
                                     input logic [63:0] ahi, input logic [63:0] slo,
                                     input logic [63:0] shi, input logic [3:0] addr,
                                     input int rf, input int wf);
    cx_op_t op;
    op = '{cmd, mlo, mhi, alo, ahi, slo, shi, addr, 1'(rf), 1'(wf)};
    return op;
  endfunction

  function automatic logic [63:0] rand_val();
    int k;
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << k;
      3:       return (64'd1 << k) - 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cx_op_t random_op();
    cx_op_t      op;
    logic [63:0] m;
    op.command = ($urandom_range(0, 99) < 6) ? 3'($urandom_range(CMD_RSVD6, CMD_RSVD7))
                                              : 3'($urandom_range(CMD_BYTE, CMD_16B));
    op.memory_low       = rand_val();
    op.memory_high      = rand_val();
    op.accum_low        = rand_val();
    op.accum_high       = rand_val();
    op.source_low       = rand_val();
    op.source_high      = rand_val();
    op.address_low_bits = 4'($urandom);
    op.read_fault       = ($urandom_range(0, 99) < 8);
    op.write_fault      = ($urandom_range(0, 99) < 15);
    if ($urandom_range(0, 1)) begin
      // mostly make the compare hit, leaving bits outside the operand random
      case (op.command)
        CMD_8B:  op.memory_low = {op.accum_high[31:0], op.accum_low[31:0]};
        CMD_16B: begin
          op.memory_low  = op.accum_low;
          op.memory_high = op.accum_high;
          if ($urandom_range(0, 3) == 0) op.memory_high[$urandom_range(0, 63)] ^= 1'b1;
        end
        default: begin
          m = operand_mask(op.command);
          op.memory_low = (op.memory_low & ~m) | (op.accum_low & m);
        end
      endcase
    end
    if ($urandom_range(0, 99) < 80) begin
      if (op.command == CMD_8B) op.address_low_bits[2:0] = 3'd0;
      if (op.command == CMD_16B) op.address_low_bits = 4'd0;
    end
    return op;
  endfunction

  task automatic test_sized_ops();
    send_op(make_op(CMD_BYTE, 64'h1234_5678_9ABC_DEFF, '0, '1, '0, '1, '1, 4'h0, 0, 0));
    send_op(make_op(CMD_BYTE, 64'h01, '1, 64'h80, '1, 64'h55, '0, 4'hF, 0, 0));
    send_op(make_op(CMD_BYTE, 64'h01, '0, 64'h10, '0, '1, '0, 4'h3, 0, 1));
    send_op(make_op(CMD_WORD, '1, '0, '0, '0, '1, '0, 4'h1, 0, 0));
    send_op(make_op(CMD_WORD, 64'hFFFF_0000_0000_8000, '0, 64'h8000, '0, '1, '1, 4'h2, 0, 0));
    send_op(make_op(CMD_DWORD, 64'hFFFF_FFFF, '0, 64'h7FFF_FFFF, '1, '0, '0, 4'h4, 0, 0));
    send_op(make_op(CMD_DWORD, 64'hAB_1234_5678, '0, 64'h1234_5678, '0, '1, '0, 4'h0, 0, 1));
    send_op(make_op(CMD_QWORD, 64'd1, '1, 64'h8000_0000_0000_0000, '1, '0, '0, 4'h8, 0, 0));
    send_op(make_op(CMD_QWORD, '1, '0, '1, '0, 64'h0123_4567_89AB_CDEF, '0, 4'h0, 0, 0));
    send_op(make_op(CMD_QWORD, '1, '1, '1, '1, '1, '1, 4'hF, 1, 1));
    wait_results_done();
  endtask

  task automatic test_wide_ops();
    logic [63:0] alo, ahi, both;
    alo  = 64'hAAAA_AAAA_1111_2222;
    ahi  = 64'h5555_5555_3333_4444;
    both = 64'h3333_4444_1111_2222;
    send_op(make_op(CMD_8B, both, '1, alo, ahi, 64'hFFFF_FFFF_8765_4321,
                    64'h0123_4567_89AB_CDEF, 4'h8, 0, 0));
    send_op(make_op(CMD_8B, '1, '0, alo, ahi, '1, '1, 4'h0, 0, 0));
    send_op(make_op(CMD_8B, both, '0, alo, ahi, '1, '1, 4'h4, 1, 1));
    send_op(make_op(CMD_8B, both, '0, alo, ahi, '1, '1, 4'h0, 1, 0));
    send_op(make_op(CMD_8B, both, '0, alo, ahi, '1, '1, 4'h8, 0, 1));
    send_op(make_op(CMD_8B, '0, '0, alo, ahi, '1, '1, 4'h0, 0, 1));
    send_op(make_op(CMD_16B, '1, '1, '1, '1, '1, '1, 4'h0, 0, 0));
    send_op(make_op(CMD_16B, alo, ~ahi, alo, ahi, '1, '0, 4'h0, 0, 1));
    send_op(make_op(CMD_16B, alo, ahi, alo, ahi, '1, '1, 4'h8, 0, 0));
    send_op(make_op(CMD_16B, alo, ahi, alo, ahi, '1, '1, 4'h1, 1, 0));
    send_op(make_op(CMD_16B, '0, '0, '0, '0, '1, '1, 4'h0, 1, 0));
    send_op(make_op(CMD_16B, '0, '0, '0, '0, '1, '1, 4'h0, 0, 1));
    wait_results_done();
  endtask

  task automatic test_unknown_cmds();
    send_op(make_op(CMD_RSVD6, '1, '1, '1, '1, '1, '1, 4'hF, 1, 1));
    send_op(make_op(CMD_RSVD7, '0, '0, '0, '0, '1, '1, 4'h0, 0, 0));
    wait_results_done();
  endtask

  task automatic test_random_mix(input int n, input int in_pct, input int out_pct);
    idle_pct_in   = in_pct;
    stall_pct_out = out_pct;
    repeat (n) send_op(random_op());
    wait_results_done();
  endtask

  // receiver holds off while the sender keeps pushing, so in_tready must drop
  task automatic test_backpressure();
    idle_pct_in   = 0;
    stall_pct_out = 0;
    @(negedge clk);
    hold_req = 60;
    @(posedge clk);
    repeat (30) send_op(random_op());
    wait_results_done();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sized_ops();
    test_wide_ops();
    test_unknown_cmds();
    test_random_mix(170, 0, 0);
    test_random_mix(170, 54, 0);
    test_random_mix(170, 0, 54);
    test_random_mix(170, 8, 8);
    test_backpressure();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- x86_compare_exchange_unit_top.f -----
hdl/xcmpx_pkg.sv
hdl/xcmpx_exec.sv
hdl/x86_compare_exchange_unit_top.sv
dv/tb_x86_compare_exchange_unit_top.sv
